FILE: hw/rtl/bfe_pkg.sv
// Shared types and constants for the binary frame encoder.
package bfe_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam int unsigned RUN_DEPTH  = 8;
    localparam int unsigned IDX_W      = $clog2(RUN_DEPTH);

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // One run of output bytes produced by a single input item.
    typedef struct packed {
        logic [RUN_DEPTH-1:0][7:0] data;
        logic [IDX_W-1:0]          last_idx;
        logic                      ends_frame;
        logic                      is_error;
    } t_run;

endpackage

FILE: hw/rtl/bfe_frame.sv
// Input register, frame state and checksum, and run builder.
module bfe_frame
    import bfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_msg_class,
    input  logic [7:0]  i_msg_id,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    input  logic        i_run_free,
    output logic        o_run_load,
    output t_run        o_run
);

    logic        r_in_valid;
    logic        r_op;
    logic [7:0]  r_class;
    logic [7:0]  r_id;
    logic [15:0] r_len;
    logic [7:0]  r_data;

    logic [7:0]  r_sum_a;
    logic [7:0]  r_sum_b;
    logic [15:0] r_bytes_left;
    logic        r_frame_open;

    logic [7:0]  n_sum_a;
    logic [7:0]  n_sum_b;
    logic [15:0] n_bytes_left;
    logic        n_frame_open;

    logic        accept;
    logic        move;

    // checksum chain terms
    logic [7:0]  a1, a2, a3, a4, b2, b3, b4;
    logic [7:0]  pa, pb;
    logic [15:0] left_dec;

    assign o_stall    = r_in_valid && !i_run_free;
    assign accept     = i_valid && !o_stall;
    assign move       = r_in_valid && i_run_free;
    assign o_run_load = move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_class <= i_msg_class;
            r_id    <= i_msg_id;
            r_len   <= i_payload_length;
            r_data  <= i_data_byte;
        end
    end

    always_comb begin
        a1 = r_class;
        a2 = a1 + r_id;
        b2 = a1 + a2;
        a3 = a2 + r_len[7:0];
        b3 = b2 + a3;
        a4 = a3 + r_len[15:8];
        b4 = b3 + a4;
        pa = r_sum_a + r_data;
        pb = r_sum_b + pa;
        left_dec = r_bytes_left - 16'd1;
    end

    always_comb begin
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_bytes_left = r_bytes_left;
        n_frame_open = r_frame_open;
        o_run        = '0;
        if (r_op == OP_HEADER) begin
            n_sum_a       = a4;
            n_sum_b       = b4;
            o_run.data[0] = SYNC_FIRST;
            o_run.data[1] = SYNC_SECOND;
            o_run.data[2] = r_class;
            o_run.data[3] = r_id;
            o_run.data[4] = r_len[7:0];
            o_run.data[5] = r_len[15:8];
            if (r_len == 16'd0) begin
                o_run.data[6]    = a4;
                o_run.data[7]    = b4;
                o_run.last_idx   = IDX_W'(7);
                o_run.ends_frame = 1'b1;
                n_frame_open     = 1'b0;
                n_bytes_left     = 16'd0;
            end else begin
                o_run.last_idx = IDX_W'(5);
                n_frame_open   = 1'b1;
                n_bytes_left   = r_len;
            end
        end else if (!r_frame_open) begin
            o_run.is_error = 1'b1;
            o_run.last_idx = IDX_W'(0);
        end else begin
            n_sum_a       = pa;
            n_sum_b       = pb;
            o_run.data[0] = r_data;
            n_bytes_left  = left_dec;
            if (left_dec == 16'd0) begin
                o_run.data[1]    = pa;
                o_run.data[2]    = pb;
                o_run.last_idx   = IDX_W'(2);
                o_run.ends_frame = 1'b1;
                n_frame_open     = 1'b0;
            end else begin
                o_run.last_idx = IDX_W'(0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a      <= 8'd0;
            r_sum_b      <= 8'd0;
            r_bytes_left <= 16'd0;
            r_frame_open <= 1'b0;
        end else if (move) begin
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
            r_bytes_left <= n_bytes_left;
            r_frame_open <= n_frame_open;
        end
    end

endmodule

FILE: hw/rtl/bfe_serializer.sv
// Run buffer that hands out one byte per output handshake.
module bfe_serializer
    import bfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_run_load,
    input  t_run       i_run,
    output logic       o_run_free,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_frame_end,
    output logic       o_error
);

    logic             r_valid;
    t_run             r_run;
    logic [IDX_W-1:0] r_idx;
    logic             take;
    logic             at_last;

    assign at_last    = (r_idx == r_run.last_idx);
    assign take       = r_valid && !i_stall;
    assign o_run_free = !r_valid || (take && at_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_run_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take && at_last) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run_load) begin
            r_run <= i_run;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_run.data[r_idx];
    assign o_run_last  = at_last;
    assign o_frame_end = at_last && r_run.ends_frame;
    assign o_error     = r_run.is_error;

endmodule

FILE: hw/rtl/binary_frame_encoder_core.sv
// Top level of the binary frame encoder with 8-bit Fletcher checksum.
//
// Input channel (i_valid / o_stall): one item per handshake. op 0 is a
// header (class, id, 16-bit length); op 1 is one payload byte.
// Output channel (o_valid / i_stall): one framed byte per handshake, with
// run_last on the last byte an item causes, frame_end on checksum B and
// error on the single zero byte sent for a payload byte outside a frame.
//
// Items pass an input register, then the frame logic builds the whole run
// (up to 8 bytes) combinationally and loads it into the run buffer. The
// output port sends one byte per cycle while the receiver does not stall:
// a header makes 6 bytes (8 for an empty frame), a payload byte 1 (3 for
// the one that closes the frame, with both checksum bytes). A new item is
// taken while the previous run is still draining.
//
// Reset (synchronous, active low) empties both stages and closes any
// frame; checksums clear. A stalled receiver holds the current byte; once
// the input register is also full, o_stall rises.
module binary_frame_encoder_core
    import bfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_msg_class,
    input  logic [7:0]  i_msg_id,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_frame_end,
    output logic        o_error
);

    logic run_free;
    logic run_load;
    t_run run;

    // frame state, checksum and run building
    bfe_frame u_frame (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_msg_class      (i_msg_class),
        .i_msg_id         (i_msg_id),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .i_run_free       (run_free),
        .o_run_load       (run_load),
        .o_run            (run)
    );

    // byte-at-a-time output of each run
    bfe_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_load  (run_load),
        .i_run       (run),
        .o_run_free  (run_free),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end),
        .o_error     (o_error)
    );

endmodule

FILE: hw/rtl/bfe_checker.sv
// Port-level checks for the binary frame encoder, bound to the top level.
module bfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_frame_end,
    input logic       o_error
);

    // error byte is a lone zero that ends its run
    a_error_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_out_byte == 8'd0 && o_run_last && !o_frame_end)
        else $error("error result malformed");

    // checksum B always ends the run
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_run_last)
        else $error("frame_end without run_last");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid after reset");

    // stalled byte holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_run_last))
        else $error("stalled output changed");

endmodule

bind binary_frame_encoder_core bfe_checker u_bfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_byte  (o_out_byte),
    .o_run_last  (o_run_last),
    .o_frame_end (o_frame_end),
    .o_error     (o_error)
);
